### rtl/thermistor_temperature_stats_macros.svh
// ----------------------------------------------------------------------------
// thermistor temperature stats - assertion macros
// shared property wrappers for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_TEMPERATURE_STATS_MACROS_SVH
`define THERMISTOR_TEMPERATURE_STATS_MACROS_SVH

// same-cycle implication, masked while reset is high
`define TTS_CHECK_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tts check failed");

// condition that must hold in the cycle after a reset cycle
`define TTS_CHECK_AFTER_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("tts reset check failed");

`endif

### rtl/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg
// widths, conversion tables and shared types of the thermistor stats block
// ----------------------------------------------------------------------------
package tts_pkg;

   localparam int TABLE_POINTS = 26;
   localparam int CODE_W       = 13;
   localparam int SEG_W        = 5;
   localparam int OFF_W        = 9;
   localparam int SPAN_W       = 5;
   localparam int PROD_W       = OFF_W + SPAN_W;
   localparam int DEN_W        = 9;
   localparam int NUM_W        = 16;
   localparam int DIV_W        = 15;
   localparam int TEMP_W       = 8;

   localparam int MAX_SENSORS_DEFAULT = 16;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [CODE_W-1:0] CODE_TOP    = 13'd4096;
   localparam logic [CODE_W-1:0] CODE_BOTTOM = 13'd261;

   // table codes, descending, point 0 is -50 C and point 25 is 100 C
   localparam logic [CODE_W-1:0] TAB_CODE [TABLE_POINTS] = '{
      13'd4096, 13'd3713, 13'd3602, 13'd3469, 13'd3313, 13'd3136, 13'd2939,
      13'd2726, 13'd2503, 13'd2275, 13'd2048, 13'd1828, 13'd1618, 13'd1424,
      13'd1245, 13'd1085, 13'd942,  13'd816,  13'd706,  13'd611,  13'd528,
      13'd458,  13'd397,  13'd344,  13'd299,  13'd261
   };

   // per segment (indexed by its lower-code point): code span
   localparam logic [DEN_W-1:0] SEG_DEN [TABLE_POINTS] = '{
      9'd1,   9'd383, 9'd111, 9'd133, 9'd156, 9'd177, 9'd197, 9'd213, 9'd223,
      9'd228, 9'd227, 9'd220, 9'd210, 9'd194, 9'd179, 9'd160, 9'd143, 9'd126,
      9'd110, 9'd95,  9'd83,  9'd70,  9'd61,  9'd53,  9'd45,  9'd38
   };

   // per segment: temperature span in degrees
   localparam logic [SPAN_W-1:0] SEG_SPAN [TABLE_POINTS] = '{
      5'd0, 5'd30, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5,
      5'd5, 5'd5,  5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5, 5'd5,
      5'd5, 5'd5
   };

   // per segment: lower-code point temperature times code span
   localparam logic signed [NUM_W-1:0] SEG_BASE [TABLE_POINTS] = '{
      16'sd0,    -16'sd7660, -16'sd1665, -16'sd1330, -16'sd780, 16'sd0,
      16'sd985,  16'sd2130,  16'sd3345,  16'sd4560,  16'sd5675, 16'sd6600,
      16'sd7350, 16'sd7760,  16'sd8055,  16'sd8000,  16'sd7865, 16'sd7560,
      16'sd7150, 16'sd6650,  16'sd6225,  16'sd5600,  16'sd5185, 16'sd4770,
      16'sd4275, 16'sd3800
   };

   typedef struct packed {
      logic [SEG_W-1:0] seg;
      logic [OFF_W-1:0] off;
      logic             below;
      logic             last;
   } work_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temperature;
      logic                     below_table;
      logic                     scan_done;
      logic signed [TEMP_W-1:0] scan_average;
      logic signed [TEMP_W-1:0] scan_lowest;
      logic signed [TEMP_W-1:0] scan_highest;
   } result_type;

endpackage

### rtl/tts_if.sv
// ----------------------------------------------------------------------------
// tts channel interfaces
// valid/ready channels for sensor codes in and temperature results out
// ----------------------------------------------------------------------------
interface tts_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] adc_code;
   logic        last_sensor;

   modport source (output valid, output adc_code, output last_sensor, input ready);
   modport sink   (input valid, input adc_code, input last_sensor, output ready);
endinterface

interface tts_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] temperature;
   logic              below_table;
   logic              scan_done;
   logic signed [7:0] scan_average;
   logic signed [7:0] scan_lowest;
   logic signed [7:0] scan_highest;

   modport source (output valid, output temperature, output below_table,
                   output scan_done, output scan_average, output scan_lowest,
                   output scan_highest, input ready);
   modport sink   (input valid, input temperature, input below_table,
                   input scan_done, input scan_average, input scan_lowest,
                   input scan_highest, output ready);
endinterface

### rtl/tts_front.sv
// ----------------------------------------------------------------------------
// tts_front
// takes sensor codes, clamps them and finds their table segment
// ----------------------------------------------------------------------------
module tts_front (
   tts_req_if.sink             req_ch,
   input  logic                queue_full,
   output logic                push_valid,
   output tts_pkg::work_type   push_data
);
   import tts_pkg::*;

   logic [CODE_W-1:0] code_c;
   logic [SEG_W-1:0]  seg;
   logic [CODE_W-1:0] diff;

   assign req_ch.ready = !queue_full;
   assign push_valid   = req_ch.valid;

   always_comb begin
      code_c = (req_ch.adc_code > 16'(CODE_TOP)) ? CODE_TOP : req_ch.adc_code[CODE_W-1:0];
      // descending table: the smallest point not above the code wins
      seg = SEG_W'(TABLE_POINTS - 1);
      for (int i = TABLE_POINTS - 1; i >= 1; i--) begin
         if (code_c >= TAB_CODE[i]) begin
            seg = SEG_W'(i);
         end
      end
      diff = code_c - TAB_CODE[seg];
      push_data.seg   = seg;
      push_data.off   = diff[OFF_W-1:0];
      push_data.below = (code_c < CODE_BOTTOM);
      push_data.last  = req_ch.last_sensor;
   end

endmodule

### rtl/tts_queue.sv
// ----------------------------------------------------------------------------
// tts_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
module tts_queue #(
   parameter int DEPTH = tts_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  tts_pkg::work_type         push_data,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output tts_pkg::work_type         pop_data,
   output tts_pkg::queue_status_type status
);
   import tts_pkg::*;

   localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);

   work_type           store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               do_push, do_pop;

   assign status.full  = (fill_ff == FILL_W'(DEPTH));
   assign status.empty = (fill_ff == '0);
   assign pop_valid    = !status.empty;
   assign pop_data     = store_ff[rd_ptr_ff];
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/tts_div.sv
// ----------------------------------------------------------------------------
// tts_div
// serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tts_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tts_pkg::div_req_type div_req,
   output tts_pkg::div_rsp_type div_rsp
);
   import tts_pkg::*;

   localparam int STEP_W = $clog2(DIV_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    trial;

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[DIV_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIV_W);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

endmodule

### rtl/tts_back.sv
// ----------------------------------------------------------------------------
// tts_back
// interpolates each queued item, keeps scan statistics, drives results
// ----------------------------------------------------------------------------
module tts_back #(
   parameter int MAX_SENSORS = tts_pkg::MAX_SENSORS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   output logic                 pop_ready,
   input  tts_pkg::work_type    pop_data,
   output tts_pkg::div_req_type div_req,
   input  tts_pkg::div_rsp_type div_rsp,
   tts_rsp_if.source            rsp_ch
);
   import tts_pkg::*;

   localparam int SUM_W = $clog2(100 * MAX_SENSORS + 1) + 1;
   localparam int CNT_W = $clog2(MAX_SENSORS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_WAIT_CONV,
      ST_STAT,
      ST_WAIT_AVG,
      ST_OUT
   } state_type;

   state_type                state_ff, state_in;
   work_type                 work_ff, work_in;
   logic                     neg_ff, neg_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic signed [TEMP_W-1:0] avg_ff, avg_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic signed [TEMP_W-1:0] lo_ff, lo_in;
   logic signed [TEMP_W-1:0] hi_ff, hi_in;
   logic                     out_valid_ff, out_valid_in;
   result_type               out_ff, out_in;

   logic [PROD_W-1:0]        prod;
   logic signed [NUM_W-1:0]  num;
   logic [DIV_W-1:0]         num_abs;
   logic signed [SUM_W-1:0]  upd_sum;
   logic [CNT_W-1:0]         upd_count;
   logic signed [TEMP_W-1:0] upd_lo, upd_hi;
   logic signed [SUM_W-1:0]  sum_mag;
   logic signed [TEMP_W-1:0] q_signed;

   assign pop_ready            = (state_ff == ST_IDLE);
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.temperature   = out_ff.temperature;
   assign rsp_ch.below_table   = out_ff.below_table;
   assign rsp_ch.scan_done     = out_ff.scan_done;
   assign rsp_ch.scan_average  = out_ff.scan_average;
   assign rsp_ch.scan_lowest   = out_ff.scan_lowest;
   assign rsp_ch.scan_highest  = out_ff.scan_highest;

   always_comb begin
      // interpolation numerator: base - span * offset
      prod    = PROD_W'(work_ff.off) * PROD_W'(SEG_SPAN[work_ff.seg]);
      num     = SEG_BASE[work_ff.seg] - NUM_W'($signed({1'b0, prod}));
      num_abs = num[NUM_W-1] ? DIV_W'(-num) : DIV_W'(num);

      // statistics after taking this temperature in, capped at the sensor limit
      upd_sum   = sum_ff;
      upd_count = count_ff;
      upd_lo    = lo_ff;
      upd_hi    = hi_ff;
      if (count_ff < CNT_W'(MAX_SENSORS)) begin
         if (count_ff == '0) begin
            upd_lo = temp_ff;
            upd_hi = temp_ff;
         end else begin
            if (temp_ff < lo_ff) upd_lo = temp_ff;
            if (temp_ff > hi_ff) upd_hi = temp_ff;
         end
         upd_sum   = sum_ff + SUM_W'(temp_ff);
         upd_count = count_ff + 1'b1;
      end
      sum_mag  = upd_sum[SUM_W-1] ? -upd_sum : upd_sum;
      q_signed = neg_ff ? -$signed(div_rsp.quotient[TEMP_W-1:0])
                        : $signed(div_rsp.quotient[TEMP_W-1:0]);

      state_in     = state_ff;
      work_in      = work_ff;
      neg_in       = neg_ff;
      temp_in      = temp_ff;
      avg_in       = avg_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_in       = out_ff;
      div_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               work_in  = pop_data;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (work_ff.below) begin
               temp_in  = '0;
               state_in = ST_STAT;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = num_abs;
               div_req.divisor  = SEG_DEN[work_ff.seg];
               neg_in           = num[NUM_W-1];
               state_in         = ST_WAIT_CONV;
            end
         end
         ST_WAIT_CONV: begin
            if (div_rsp.done) begin
               temp_in  = q_signed;
               state_in = ST_STAT;
            end
         end
         ST_STAT: begin
            sum_in   = upd_sum;
            count_in = upd_count;
            lo_in    = upd_lo;
            hi_in    = upd_hi;
            if (work_ff.last) begin
               // count is at least one here: this item was just counted or the cap is full
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'($unsigned(sum_mag));
               div_req.divisor  = DEN_W'(upd_count);
               neg_in           = upd_sum[SUM_W-1];
               state_in         = ST_WAIT_AVG;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_WAIT_AVG: begin
            if (div_rsp.done) begin
               avg_in   = q_signed;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in       = 1'b1;
               out_in.temperature = temp_ff;
               out_in.below_table = work_ff.below;
               out_in.scan_done   = work_ff.last;
               if (work_ff.last) begin
                  out_in.scan_average = avg_ff;
                  out_in.scan_lowest  = lo_ff;
                  out_in.scan_highest = hi_ff;
                  sum_in   = '0;
                  count_in = '0;
                  lo_in    = '0;
                  hi_in    = '0;
               end else begin
                  out_in.scan_average = '0;
                  out_in.scan_lowest  = '0;
                  out_in.scan_highest = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         out_valid_ff <= out_valid_in;
      end
      work_ff <= work_in;
      neg_ff  <= neg_in;
      temp_ff <= temp_in;
      avg_ff  <= avg_in;
      out_ff  <= out_in;
   end

endmodule

### rtl/thermistor_temperature_stats.sv
// ----------------------------------------------------------------------------
// thermistor_temperature_stats
// thermistor code to degrees C with per-scan average, lowest and highest
// ----------------------------------------------------------------------------
// Each transfer on req_ch carries one converter code (0.1 mV steps) and a
// flag for the last sensor of a scan; each gives exactly one transfer on
// rsp_ch, in order. Codes are clamped to 4096, looked up in a 26-point table
// and linearly interpolated, truncating toward zero; codes under 261 give 0
// with below_table set. The closing item of a scan also carries the average,
// lowest and highest of up to MAX_SENSORS temperatures and clears the scan.
// The back part takes the next item only once the current result is
// registered, and a result waits while the previous one still waits for
// rsp_ch.ready; it uses the 15-step serial divider, shared by
// interpolation and averaging, and codes below the table skip the
// interpolation division. The front takes items at once while the queue
// (QUEUE_DEPTH entries) has room.
module thermistor_temperature_stats #(
   parameter int MAX_SENSORS = tts_pkg::MAX_SENSORS_DEFAULT,
   parameter int QUEUE_DEPTH = tts_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tts_req_if.sink    req_ch,
   tts_rsp_if.source  rsp_ch
);
   import tts_pkg::*;

   `include "thermistor_temperature_stats_macros.svh"

   // front to queue
   logic             push_valid;
   work_type         push_data;
   queue_status_type q_status;

   // queue to back
   logic             pop_valid;
   logic             pop_ready;
   work_type         pop_data;

   // back to shared divider
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   // terms for the checks below
   logic             scan_fields_zero;
   logic             avg_between;
   logic             temp_in_range;

   // classify: clamp, range flag, table segment and offset
   tts_front u_front (
      .req_ch     (req_ch),
      .queue_full (q_status.full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // decoupling queue so intake and arithmetic stall independently
   tts_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .status     (q_status)
   );

   // one quotient bit a cycle
   tts_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // interpolation, statistics and result register
   tts_back #(
      .MAX_SENSORS (MAX_SENSORS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .div_req   (div_req),
      .div_rsp   (div_rsp),
      .rsp_ch    (rsp_ch)
   );

   assign scan_fields_zero = (rsp_ch.scan_average == 8'sd0) &&
                             (rsp_ch.scan_lowest == 8'sd0) &&
                             (rsp_ch.scan_highest == 8'sd0);
   assign avg_between      = (rsp_ch.scan_lowest <= rsp_ch.scan_average) &&
                             (rsp_ch.scan_average <= rsp_ch.scan_highest);
   assign temp_in_range    = (rsp_ch.temperature >= -8'sd50) &&
                             (rsp_ch.temperature <= 8'sd100);

   // codes below the table must report a zero temperature
   `TTS_CHECK_IMP(a_below_zero, rsp_ch.valid && rsp_ch.below_table, rsp_ch.temperature == 8'sd0)

   // scan fields are zero unless the scan closes
   `TTS_CHECK_IMP(a_open_scan_zero, rsp_ch.valid && !rsp_ch.scan_done, scan_fields_zero)

   // a truncated mean lies between the extremes
   `TTS_CHECK_IMP(a_avg_bounded, rsp_ch.valid && rsp_ch.scan_done, avg_between)

   // interpolation stays inside the table's temperature range
   `TTS_CHECK_IMP(a_temp_range, rsp_ch.valid, temp_in_range)

   // no stale result survives a reset
   `TTS_CHECK_AFTER_RESET(a_reset_idle, !rsp_ch.valid)

endmodule
